@@ hdl/sma_pkg.sv @@
// Shared types and constants for the stack machine ALU.
package sma_pkg;

  localparam int DATA_W    = 32;
  localparam int OP_W      = 4;
  localparam int STATUS_W  = 2;
  localparam int DEPTH_W   = 11;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [OP_W-1:0] {
    OP_CONST = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_MUL   = 4'd3,
    OP_DIV   = 4'd4,
    OP_MAX   = 4'd5,
    OP_MIN   = 4'd6,
    OP_NEG   = 4'd7,
    OP_DUP   = 4'd8,
    OP_SWAP  = 4'd9,
    OP_END   = 4'd10
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_DIVZ  = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OPND,
    S_MUL,
    S_DIV,
    S_SWAP2,
    S_REFILL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ hdl/stack_machine_alu.sv @@
// One item is handled at a time. Const, neg, dup, unused opcodes, underflow and full faults,
// and end of the last entry go straight to the result; add, sub, max, min, other end and a
// zero divisor first wait for the read of the entry below; mul and swap then pass through S_MUL
// or S_SWAP2, and div waits on the bit-serial divider. The next item is accepted the cycle after
// the result is registered, even while it waits on out_tready. Reset (synchronous, rst_n low) empties the
// stack; memory contents are not cleared. Top of stack is mirrored in a register.
module stack_machine_alu #(
  parameter int STACK_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [sma_pkg::DATA_W-1:0]          in_tdata,  // [31:0] operand_value
  input  logic [sma_pkg::OP_W-1:0]            in_tuser,  // [3:0] req_type
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [sma_pkg::OUT_TDATA_W-1:0]     out_tdata, // [31:0] top_value, [42:32] depth
  output logic [sma_pkg::STATUS_W-1:0]        out_tuser  // [1:0] status
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int DW = sma_pkg::DATA_W;

  sma_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   d_r, d_nxt;
  logic [DW-1:0]   top_r, top_nxt;
  logic [DW-1:0]   tmp_r, tmp_nxt;
  logic [DW-1:0]   prod_r;
  logic [sma_pkg::OP_W-1:0]     op_r, op_nxt;
  logic [sma_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic            pop_r, pop_nxt;

  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [DW-1:0]   mem_wdata, mem_rdata;

  sma_pkg::div_req_t div_req;
  sma_pkg::div_rsp_t div_rsp;

  logic            lt1, lt2, full, out_free;
  logic [CW-1:0]   dm1, dm2, dp1;
  logic [DW-1:0]   alu;
  logic [DW-1:0]   rep_top;

  sma_stack_mem #(.DEPTH(STACK_DEPTH), .ADDR_W(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sma_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign lt1      = d_r == '0;
  assign lt2      = d_r < CW'(2);
  assign full     = d_r >= CW'(STACK_DEPTH);
  assign dm1      = d_r - 1'b1;
  assign dm2      = d_r - CW'(2);
  assign dp1      = d_r + 1'b1;
  assign out_free = !out_tvalid || out_tready;
  assign in_tready = state_r == sma_pkg::S_IDLE;

  // a = top, b = entry below
  always_comb begin
    case (op_r)
      sma_pkg::OP_ADD: alu = top_r + mem_rdata;
      sma_pkg::OP_SUB: alu = top_r - mem_rdata;
      sma_pkg::OP_MAX: alu = ($signed(top_r) > $signed(mem_rdata)) ? top_r : mem_rdata;
      sma_pkg::OP_MIN: alu = ($signed(mem_rdata) > $signed(top_r)) ? top_r : mem_rdata;
      default:         alu = mem_rdata;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sma_pkg::S_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            sma_pkg::OP_ADD, sma_pkg::OP_SUB, sma_pkg::OP_MUL, sma_pkg::OP_DIV,
            sma_pkg::OP_MAX, sma_pkg::OP_MIN, sma_pkg::OP_SWAP:
              state_nxt = lt2 ? sma_pkg::S_DONE : sma_pkg::S_OPND;
            sma_pkg::OP_END:
              state_nxt = lt2 ? sma_pkg::S_DONE : sma_pkg::S_REFILL;
            default:
              state_nxt = sma_pkg::S_DONE;
          endcase
        end
      end
      sma_pkg::S_OPND: begin
        case (op_r)
          sma_pkg::OP_MUL:  state_nxt = sma_pkg::S_MUL;
          sma_pkg::OP_DIV:  state_nxt = (mem_rdata == '0) ? sma_pkg::S_DONE : sma_pkg::S_DIV;
          sma_pkg::OP_SWAP: state_nxt = sma_pkg::S_SWAP2;
          default:          state_nxt = sma_pkg::S_DONE;
        endcase
      end
      sma_pkg::S_MUL:    state_nxt = sma_pkg::S_DONE;
      sma_pkg::S_DIV:    if (div_rsp.done) state_nxt = sma_pkg::S_DONE;
      sma_pkg::S_SWAP2:  state_nxt = sma_pkg::S_DONE;
      sma_pkg::S_REFILL: state_nxt = sma_pkg::S_DONE;
      sma_pkg::S_DONE:   if (out_free) state_nxt = sma_pkg::S_IDLE;
      default:           state_nxt = sma_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    d_nxt            = d_r;
    top_nxt          = top_r;
    tmp_nxt          = tmp_r;
    op_nxt           = op_r;
    status_nxt       = status_r;
    pop_nxt          = pop_r;
    mem_we           = 1'b0;
    mem_waddr        = d_r[AW-1:0];
    mem_wdata        = top_r;
    mem_re           = 1'b0;
    mem_raddr        = dm2[AW-1:0];
    div_req.start    = 1'b0;
    div_req.dividend = top_r;
    div_req.divisor  = mem_rdata;
    case (state_r)
      sma_pkg::S_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = in_tuser;
          status_nxt = sma_pkg::ST_OK;
          pop_nxt    = 1'b0;
          case (in_tuser)
            sma_pkg::OP_CONST: begin
              if (full) begin
                status_nxt = sma_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_wdata = in_tdata;
                top_nxt   = in_tdata;
                d_nxt     = dp1;
              end
            end
            sma_pkg::OP_ADD, sma_pkg::OP_SUB, sma_pkg::OP_MUL, sma_pkg::OP_DIV,
            sma_pkg::OP_MAX, sma_pkg::OP_MIN, sma_pkg::OP_SWAP: begin
              if (lt2) status_nxt = sma_pkg::ST_UNDER;
              else mem_re = 1'b1;
            end
            sma_pkg::OP_NEG: begin
              if (lt1) begin
                status_nxt = sma_pkg::ST_UNDER;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = dm1[AW-1:0];
                mem_wdata = ~top_r + 1'b1;
                top_nxt   = ~top_r + 1'b1;
              end
            end
            sma_pkg::OP_DUP: begin
              if (lt1) begin
                status_nxt = sma_pkg::ST_UNDER;
              end else if (full) begin
                status_nxt = sma_pkg::ST_FULL;
              end else begin
                mem_we = 1'b1;
                d_nxt  = dp1;
              end
            end
            sma_pkg::OP_END: begin
              if (lt1) begin
                status_nxt = sma_pkg::ST_UNDER;
              end else begin
                pop_nxt = 1'b1;
                tmp_nxt = top_r;
                d_nxt   = dm1;
                mem_re  = !lt2;
              end
            end
            default: ;
          endcase
        end
      end
      sma_pkg::S_OPND: begin
        case (op_r)
          sma_pkg::OP_ADD, sma_pkg::OP_SUB, sma_pkg::OP_MAX, sma_pkg::OP_MIN: begin
            mem_we    = 1'b1;
            mem_waddr = dm2[AW-1:0];
            mem_wdata = alu;
            top_nxt   = alu;
            d_nxt     = dm1;
          end
          sma_pkg::OP_DIV: begin
            if (mem_rdata == '0) status_nxt = sma_pkg::ST_DIVZ;
            else div_req.start = 1'b1;
          end
          sma_pkg::OP_SWAP: begin
            mem_we    = 1'b1;
            mem_waddr = dm1[AW-1:0];
            mem_wdata = mem_rdata;
            top_nxt   = mem_rdata;
            tmp_nxt   = top_r;
          end
          default: ;
        endcase
      end
      sma_pkg::S_MUL: begin
        mem_we    = 1'b1;
        mem_waddr = dm2[AW-1:0];
        mem_wdata = prod_r;
        top_nxt   = prod_r;
        d_nxt     = dm1;
      end
      sma_pkg::S_DIV: begin
        if (div_rsp.done) begin
          mem_we    = 1'b1;
          mem_waddr = dm2[AW-1:0];
          mem_wdata = div_rsp.quotient;
          top_nxt   = div_rsp.quotient;
          d_nxt     = dm1;
        end
      end
      sma_pkg::S_SWAP2: begin
        // d_r is unchanged by swap, so d-2 is still the lower entry
        mem_we    = 1'b1;
        mem_waddr = dm2[AW-1:0];
        mem_wdata = tmp_r;
      end
      sma_pkg::S_REFILL: begin
        top_nxt = mem_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sma_pkg::S_IDLE;
      d_r     <= '0;
    end else begin
      state_r <= state_nxt;
      d_r     <= d_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r    <= top_nxt;
    tmp_r    <= tmp_nxt;
    op_r     <= op_nxt;
    status_r <= status_nxt;
    pop_r    <= pop_nxt;
    if (state_r == sma_pkg::S_OPND) begin
      prod_r <= top_r * mem_rdata;
    end
  end

  assign rep_top = pop_r ? tmp_r : (lt1 ? '0 : top_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (state_r == sma_pkg::S_DONE && out_free) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sma_pkg::S_DONE && out_free) begin
      out_tdata <= {{(sma_pkg::OUT_TDATA_W - DW - sma_pkg::DEPTH_W){1'b0}},
                    (sma_pkg::DEPTH_W)'(d_r), rep_top};
      out_tuser <= status_r;
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    d_r <= CW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> div_req.divisor != '0)
    else $error("divider started with zero divisor");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item accepted while one is in flight");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re && mem_waddr == mem_raddr))
    else $error("read and write of the same stack entry in one cycle");

endmodule

@@ hdl/sma_stack_mem.sv @@
// Stack storage: one write port, one registered read port.
module sma_stack_mem #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ADDR_W-1:0]          waddr,
  input  logic [sma_pkg::DATA_W-1:0] wdata,
  input  logic                       re,
  input  logic [ADDR_W-1:0]          raddr,
  output logic [sma_pkg::DATA_W-1:0] rdata
);

  logic [sma_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/sma_div.sv @@
// Bit-serial signed divider, truncating toward zero, one quotient bit per cycle.
module sma_div (
  input  logic              clk,
  input  logic              rst_n,
  input  sma_pkg::div_req_t req,
  output sma_pkg::div_rsp_t rsp
);

  localparam int DW    = sma_pkg::DATA_W;
  localparam int CNT_W = $clog2(DW);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    quo_r;
  logic [DW-1:0]    dvs_r;
  logic             neg_r;

  logic [DW-1:0] mag_a;
  logic [DW-1:0] mag_b;
  logic [DW:0]   rem_sh;
  logic          ge;
  logic [DW:0]   rem_new;

  assign mag_a   = req.dividend[DW-1] ? (~req.dividend + 1'b1) : req.dividend;
  assign mag_b   = req.divisor[DW-1]  ? (~req.divisor + 1'b1)  : req.divisor;
  assign rem_sh  = {rem_r, quo_r[DW-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_new = ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // pulses for one cycle after the last quotient bit
      done_r <= busy_r && !req.start && (cnt_r == CNT_W'(DW - 1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DW - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= mag_a;
      dvs_r <= mag_b;
      neg_r <= req.dividend[DW-1] ^ req.divisor[DW-1];
    end else if (busy_r) begin
      rem_r <= rem_new[DW-1:0];
      quo_r <= {quo_r[DW-2:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule

@@ dv/stack_machine_alu_check.sv @@
// Checker for stack_machine_alu: predicts every result from the accepted items and compares.
module stack_machine_alu_check #(
  parameter int STACK_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [sma_pkg::DATA_W-1:0]      in_tdata,   // [31:0] operand_value
  input  logic [sma_pkg::OP_W-1:0]        in_tuser,   // [3:0] req_type
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [sma_pkg::OUT_TDATA_W-1:0] out_tdata,  // [31:0] top_value, [42:32] depth
  input  logic [sma_pkg::STATUS_W-1:0]    out_tuser,  // [1:0] status
  output int                              fail_count,
  output int                              pending,
  output int                              result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW     = sma_pkg::DATA_W;
  localparam int DEPTHW = sma_pkg::DEPTH_W;

  typedef struct packed {
    sma_pkg::status_t  status;
    logic [DW-1:0]     top;
    logic [DEPTHW-1:0] depth;
  } alu_result_t;

  logic [DW-1:0] stack_mem [STACK_DEPTH];
  int            stack_ptr;
  alu_result_t   result_q[$];

  // Executes one instruction on the shadow stack and returns what the block should report.
  function automatic alu_result_t exec_instr(input logic [sma_pkg::OP_W-1:0] opcode,
                                             input logic [DW-1:0] operand);
    alu_result_t       res;
    logic [DW-1:0]     a, b, r, q, ma, mb, report;
    sma_pkg::status_t  st;
    logic              popped;
    int                d;
    d      = stack_ptr;
    st     = sma_pkg::ST_OK;
    popped = 1'b0;
    report = '0;
    r      = '0;
    case (opcode)
      sma_pkg::OP_CONST: begin
        if (d >= STACK_DEPTH) begin
          st = sma_pkg::ST_FULL;
        end else begin
          stack_mem[d] = operand;
          stack_ptr = d + 1;
        end
      end
      sma_pkg::OP_ADD, sma_pkg::OP_SUB, sma_pkg::OP_MUL, sma_pkg::OP_DIV,
      sma_pkg::OP_MAX, sma_pkg::OP_MIN: begin
        if (d < 2) begin
          st = sma_pkg::ST_UNDER;
        end else begin
          // top is the left operand, the entry below it the right one
          a = stack_mem[d-1];
          b = stack_mem[d-2];
          case (opcode)
            sma_pkg::OP_ADD: r = a + b;
            sma_pkg::OP_SUB: r = a - b;
            sma_pkg::OP_MUL: r = a * b;
            sma_pkg::OP_DIV: begin
              if (b == '0) begin
                st = sma_pkg::ST_DIVZ;
              end else begin
                ma = a[DW-1] ? -a : a;
                mb = b[DW-1] ? -b : b;
                q  = ma / mb;
                r  = (a[DW-1] ^ b[DW-1]) ? -q : q;
              end
            end
            sma_pkg::OP_MAX: r = ($signed(a) > $signed(b)) ? a : b;
            default:         r = ($signed(b) > $signed(a)) ? a : b;
          endcase
          if (st == sma_pkg::ST_OK) begin
            stack_mem[d-2] = r;
            stack_ptr = d - 1;
          end
        end
      end
      sma_pkg::OP_NEG: begin
        if (d < 1) st = sma_pkg::ST_UNDER;
        else stack_mem[d-1] = -stack_mem[d-1];
      end
      sma_pkg::OP_DUP: begin
        if (d < 1) begin
          st = sma_pkg::ST_UNDER;
        end else if (d >= STACK_DEPTH) begin
          st = sma_pkg::ST_FULL;
        end else begin
          stack_mem[d] = stack_mem[d-1];
          stack_ptr = d + 1;
        end
      end
      sma_pkg::OP_SWAP: begin
        if (d < 2) begin
          st = sma_pkg::ST_UNDER;
        end else begin
          r = stack_mem[d-1];
          stack_mem[d-1] = stack_mem[d-2];
          stack_mem[d-2] = r;
        end
      end
      sma_pkg::OP_END: begin
        if (d < 1) begin
          st = sma_pkg::ST_UNDER;
        end else begin
          report = stack_mem[d-1];
          popped = 1'b1;
          stack_ptr = d - 1;
        end
      end
      default: ;  // unused opcodes leave everything alone
    endcase
    if (!popped) report = (stack_ptr != 0) ? stack_mem[stack_ptr-1] : '0;
    res.status = st;
    res.top    = report;
    res.depth  = DEPTHW'(stack_ptr);
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    alu_result_t want;
    if (!rst_n) begin
      stack_ptr    = 0;
      fail_count   = 0;
      result_count = 0;
      result_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        result_count++;
        if (result_q.size() == 0) begin
          $error("result with no instruction outstanding: tdata %h tuser %h",
                 out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          if (out_tuser != want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tuser);
            fail_count++;
          end
          if (out_tdata[31:0] != want.top) begin
            $error("top_value: expected %0d, got %0d",
                   $signed(want.top), $signed(out_tdata[31:0]));
            fail_count++;
          end
          if (out_tdata[42:32] != want.depth) begin
            $error("depth: expected %0d, got %0d", want.depth, out_tdata[42:32]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) result_q.push_back(exec_instr(in_tuser, in_tdata));
    end
    pending = result_q.size();
  end

endmodule

@@ dv/stack_machine_alu_test.sv @@
// Testbench top for stack_machine_alu: clock, reset, instruction stimulus and verdict.
module stack_machine_alu_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_DEPTH = 1024;
  localparam int OPW = sma_pkg::OP_W;
  localparam int DW  = sma_pkg::DATA_W;
  localparam logic [OPW-1:0] OP_NOP_LO = 4'd11;
  localparam logic [OPW-1:0] OP_NOP_HI = 4'd15;
  localparam logic [DW-1:0] INT_MIN = 32'h8000_0000;
  localparam logic [DW-1:0] INT_MAX = 32'h7FFF_FFFF;
  localparam logic [DW-1:0] MINUS_ONE = 32'hFFFF_FFFF;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [DW-1:0]                   in_tdata = '0;
  logic [OPW-1:0]                  in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [sma_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [sma_pkg::STATUS_W-1:0]    out_tuser;

  int fail_count, pending, result_count;
  int send_idle_pct = 6;
  int recv_idle_pct = 70;
  int sent_count = 0;

  stack_machine_alu #(.STACK_DEPTH(STACK_DEPTH)) uut (.*);

  stack_machine_alu_check #(.STACK_DEPTH(STACK_DEPTH)) checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  initial begin
    #8ms;
    $display("stack_machine_alu_test NOT OK");
    $finish;
  end

  // Holds the item until accepted, then idles per the current sender setting.
  task automatic issue_instr(input logic [OPW-1:0] opcode, input logic [DW-1:0] operand);
    in_tvalid <= 1'b1;
    in_tdata  <= operand;
    in_tuser  <= opcode;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic logic [OPW-1:0] pick_opcode();
    int roll;
    roll = $urandom_range(99);
    if (roll < 35) return sma_pkg::OP_CONST;
    if (roll < 70) begin
      return sma_pkg::OP_ADD + OPW'($urandom_range(sma_pkg::OP_MIN - sma_pkg::OP_ADD));
    end
    if (roll < 75) return sma_pkg::OP_NEG;
    if (roll < 82) return sma_pkg::OP_DUP;
    if (roll < 88) return sma_pkg::OP_SWAP;
    if (roll < 95) return sma_pkg::OP_END;
    return OPW'($urandom_range(OP_NOP_HI, OP_NOP_LO));
  endfunction

  // Mix of corner values, small values (zero divisors, minus one) and full-range values.
  function automatic logic [DW-1:0] pick_operand();
    int roll;
    roll = $urandom_range(99);
    if (roll < 25) begin
      case ($urandom_range(3))
        0:       return INT_MIN;
        1:       return INT_MAX;
        2:       return MINUS_ONE;
        default: return '0;
      endcase
    end
    if (roll < 50) return DW'($urandom_range(8)) - DW'(4);
    return $urandom;
  endfunction

  task automatic run_mixed(input int count);
    repeat (count) issue_instr(pick_opcode(), pick_operand());
  endtask

  initial begin
    int guard;
    logic [OPW-1:0] full_ops [4];
    full_ops = '{sma_pkg::OP_CONST, sma_pkg::OP_DUP, sma_pkg::OP_NEG, sma_pkg::OP_SWAP};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // empty-stack faults
    issue_instr(sma_pkg::OP_END,  pick_operand());
    issue_instr(sma_pkg::OP_ADD,  pick_operand());
    issue_instr(sma_pkg::OP_NEG,  pick_operand());
    issue_instr(sma_pkg::OP_DUP,  pick_operand());
    issue_instr(sma_pkg::OP_SWAP, pick_operand());
    // most negative over minus one, with a single-entry binary op first
    issue_instr(sma_pkg::OP_CONST, MINUS_ONE);
    issue_instr(sma_pkg::OP_SUB,   pick_operand());
    issue_instr(sma_pkg::OP_CONST, INT_MIN);
    issue_instr(sma_pkg::OP_DIV,   pick_operand());
    // zero divisor
    issue_instr(sma_pkg::OP_CONST, '0);
    issue_instr(sma_pkg::OP_CONST, 32'd7);
    issue_instr(sma_pkg::OP_DIV,   pick_operand());
    issue_instr(sma_pkg::OP_SWAP,  pick_operand());
    issue_instr(sma_pkg::OP_ADD,   pick_operand());
    issue_instr(sma_pkg::OP_SUB,   pick_operand());
    issue_instr(sma_pkg::OP_CONST, INT_MAX);
    issue_instr(sma_pkg::OP_MUL,   pick_operand());
    issue_instr(sma_pkg::OP_CONST, -32'sd5);
    issue_instr(sma_pkg::OP_MAX,   pick_operand());
    issue_instr(sma_pkg::OP_CONST, 32'd3);
    issue_instr(sma_pkg::OP_MIN,   pick_operand());
    issue_instr(sma_pkg::OP_DUP,   pick_operand());
    issue_instr(OP_NOP_LO, MINUS_ONE);
    issue_instr(sma_pkg::OP_END,   pick_operand());
    issue_instr(sma_pkg::OP_END,   pick_operand());

    run_mixed(420);
    send_idle_pct = 70;
    recv_idle_pct = 6;
    run_mixed(420);
    send_idle_pct = 0;
    recv_idle_pct = 0;

    // push past capacity so the full-stack drop is exercised, then work at full
    repeat (1040) begin
      issue_instr(($urandom_range(9) == 0) ? sma_pkg::OP_DUP : sma_pkg::OP_CONST,
                  pick_operand());
    end
    repeat (10) issue_instr(full_ops[$urandom_range(3)], pick_operand());
    run_mixed(60);
    in_tvalid <= 1'b0;

    guard = 0;
    while (pending != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);

    $display("%0d instructions issued over three stall mixes, including a run to a full stack",
             sent_count);
    $display("%0d results compared on status, top_value and depth", result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("stack_machine_alu_test OK");
    end else begin
      $display("stack_machine_alu_test NOT OK");
    end
    $finish;
  end

endmodule
